/* sv/bmc_pkg.sv */
package bmc_pkg;

    // Result status codes.
    localparam logic [2:0] ST_COMPLETE = 3'd0;
    localparam logic [2:0] ST_CORRUPT  = 3'd1;
    localparam logic [2:0] ST_BALANCED = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    // Longest completion run that one line end may emit.
    localparam int MAX_RESULTS = 32;

    // Bracket characters in ASCII.
    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    // Opener kinds as stored on the stack.
    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] kind;
    } char_class_t;

    // Classify one character as opener, closer or neither.
    function automatic char_class_t classify(input logic [7:0] ch);
        char_class_t c;
        c = '0;
        case (ch)
            CH_OPEN_PAREN:   begin c.is_open  = 1'b1; c.kind = KIND_PAREN;  end
            CH_OPEN_SQUARE:  begin c.is_open  = 1'b1; c.kind = KIND_SQUARE; end
            CH_OPEN_CURLY:   begin c.is_open  = 1'b1; c.kind = KIND_CURLY;  end
            CH_OPEN_ANGLE:   begin c.is_open  = 1'b1; c.kind = KIND_ANGLE;  end
            CH_CLOSE_PAREN:  begin c.is_close = 1'b1; c.kind = KIND_PAREN;  end
            CH_CLOSE_SQUARE: begin c.is_close = 1'b1; c.kind = KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin c.is_close = 1'b1; c.kind = KIND_CURLY;  end
            CH_CLOSE_ANGLE:  begin c.is_close = 1'b1; c.kind = KIND_ANGLE;  end
            default:         c = '0;
        endcase
        return c;
    endfunction

    // Closing character for a stored opener kind.
    function automatic logic [7:0] close_char(input logic [1:0] kind);
        logic [7:0] ch;
        case (kind)
            KIND_PAREN:  ch = CH_CLOSE_PAREN;
            KIND_SQUARE: ch = CH_CLOSE_SQUARE;
            KIND_CURLY:  ch = CH_CLOSE_CURLY;
            KIND_ANGLE:  ch = CH_CLOSE_ANGLE;
            default:     ch = CH_CLOSE_PAREN;
        endcase
        return ch;
    endfunction

endpackage

/* sv/bracket_match_completion.sv */
// An opener or a non-bracket character is handled in S_IDLE; a closer also passes S_CHECK
// as the top entry comes from the registered stack memory read. Openers go at 1 word per
// cycle while the output is free; input waits while a closer is checked or a run drains.
// A line end that leaves open brackets emits each completion word through S_DRAIN_RD and
// S_DRAIN_OUT (stack memory read each). Reset (rst_n low, asynchronous) empties
// the stack, clears line state and out_valid; stack memory is not cleared and needs none.
module bracket_match_completion
    import bmc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] status, [10:3] char_out, [15:11] zero
    output logic        m_tlast    // last_of_run
);

    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W   = $clog2(STACK_DEPTH);
    localparam int EMIT_MAX = (STACK_DEPTH < MAX_RESULTS) ? STACK_DEPTH : MAX_RESULTS;

    // Sequencer states.
    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_CHECK     = 2'd1;
    localparam logic [1:0] S_DRAIN_RD  = 2'd2;
    localparam logic [1:0] S_DRAIN_OUT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              failed_reg, failed_next;
    logic              eol_reg, eol_next;
    logic [7:0]        char_reg, char_next;
    logic [1:0]        kind_reg, kind_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  left_reg, left_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    // Stack memory and its ports.
    logic [1:0]        stack_mem [STACK_DEPTH];
    logic [1:0]        rd_data_reg;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [1:0]        wr_data;

    logic              out_free;
    logic              in_take;
    char_class_t       in_class;
    logic [CNT_W-1:0]  pop_count;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_take  = s_tvalid && s_tready;
    assign in_class = classify(s_tdata);
    assign pop_count = count_reg - CNT_W'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_char_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    // Synchronous stack memory, one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // Next-state logic of the sequencer, stack pointer and output register.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        failed_next     = failed_reg;
        eol_next        = eol_reg;
        char_next       = char_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        left_next       = left_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[ADDR_W-1:0];
        wr_data         = in_class.kind;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    char_next = s_tdata;
                    kind_next = in_class.kind;
                    eol_next  = s_tlast;
                    if (failed_reg)
                    begin
                        // Rest of a failed line is dropped.
                        if (s_tlast)
                        begin
                            failed_next = 1'b0;
                            count_next  = '0;
                        end
                    end
                    else if (in_class.is_open)
                    begin
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_OVERFLOW;
                            out_char_next   = s_tdata;
                            out_last_next   = 1'b1;
                            failed_next     = !s_tlast;
                            if (s_tlast)
                            begin
                                count_next = '0;
                            end
                        end
                        else
                        begin
                            // Push, then drain from the new top on a line end.
                            wr_en = 1'b1;
                            if (s_tlast)
                            begin
                                count_next = '0;
                                idx_next   = count_reg[ADDR_W-1:0];
                                left_next  = (count_reg + CNT_W'(1) < CNT_W'(EMIT_MAX)) ?
                                             count_reg + CNT_W'(1) : CNT_W'(EMIT_MAX);
                                state_next = S_DRAIN_RD;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    else if (in_class.is_close)
                    begin
                        if (count_reg == '0)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_CORRUPT;
                            out_char_next   = s_tdata;
                            out_last_next   = 1'b1;
                            failed_next     = !s_tlast;
                        end
                        else
                        begin
                            // Fetch the top entry for the match check.
                            rd_en      = 1'b1;
                            rd_addr    = pop_count[ADDR_W-1:0];
                            count_next = pop_count;
                            state_next = S_CHECK;
                        end
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_INVALID;
                        out_char_next   = s_tdata;
                        out_last_next   = 1'b1;
                        failed_next     = !s_tlast;
                        if (s_tlast)
                        begin
                            count_next = '0;
                        end
                    end
                end
            end

            S_CHECK:
            begin
                if (out_free)
                begin
                    if (rd_data_reg != kind_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_CORRUPT;
                        out_char_next   = char_reg;
                        out_last_next   = 1'b1;
                        failed_next     = !eol_reg;
                        if (eol_reg)
                        begin
                            count_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else if (eol_reg && count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_BALANCED;
                        out_char_next   = 8'h00;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (eol_reg)
                    begin
                        count_next = '0;
                        idx_next   = pop_count[ADDR_W-1:0];
                        left_next  = (count_reg < CNT_W'(EMIT_MAX)) ?
                                     count_reg : CNT_W'(EMIT_MAX);
                        state_next = S_DRAIN_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_DRAIN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_DRAIN_OUT;
            end

            S_DRAIN_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_COMPLETE;
                    out_char_next   = close_char(rd_data_reg);
                    out_last_next   = (left_reg == CNT_W'(1));
                    left_next       = left_reg - CNT_W'(1);
                    idx_next        = idx_reg - ADDR_W'(1);
                    state_next      = (left_reg == CNT_W'(1)) ? S_IDLE : S_DRAIN_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        eol_reg        <= eol_next;
        char_reg       <= char_next;
        kind_reg       <= kind_next;
        idx_reg        <= idx_next;
        left_reg       <= left_next;
        out_status_reg <= out_status_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
    end

endmodule

/* sv/bmc_checker.sv */
module bmc_assertions
    import bmc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A stalled output word holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Status codes stay within the defined set and padding stays zero.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= ST_INVALID && m_tdata[15:11] == 5'd0)
        else $error("bad status code or padding");

    // Every result other than a completion character closes its run.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != ST_COMPLETE |-> m_tlast)
        else $error("error or balanced word without last");

    // A balanced result carries no character.
    a_balanced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == ST_BALANCED |-> m_tdata[10:3] == 8'h00)
        else $error("balanced word with a character");

    // Completion words only carry closing brackets.
    a_complete_closer: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == ST_COMPLETE |->
            m_tdata[10:3] == CH_CLOSE_PAREN || m_tdata[10:3] == CH_CLOSE_SQUARE ||
            m_tdata[10:3] == CH_CLOSE_CURLY || m_tdata[10:3] == CH_CLOSE_ANGLE)
        else $error("completion word is not a closer");

endmodule

bind bracket_match_completion bmc_assertions u_bmc_assertions (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* bench/bmc_checker.sv */
`timescale 1ns / 100ps

// Watches both stream channels of the bracket matcher, predicts the result
// words of every accepted character and compares them in order.
module bmc_checker
    import bmc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending,
    output int          checked,
    output int          completions
);

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] char_out;
        logic       last_of_run;
    } result_t;

    // Expected result words, oldest first.
    result_t expected_q[$];

    // Shadow copy of the bracket stack and the line state.
    logic [1:0] open_kinds [STACK_DEPTH];
    int         open_count;
    bit         line_dead;

    function automatic logic [7:0] opener_for(input logic [1:0] kind);
        case (kind)
            KIND_PAREN:  return CH_OPEN_PAREN;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            KIND_CURLY:  return CH_OPEN_CURLY;
            default:     return CH_OPEN_ANGLE;
        endcase
    endfunction

    function automatic logic [7:0] closer_for(input logic [1:0] kind);
        case (kind)
            KIND_PAREN:  return CH_CLOSE_PAREN;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            KIND_CURLY:  return CH_CLOSE_CURLY;
            default:     return CH_CLOSE_ANGLE;
        endcase
    endfunction

    task automatic expect_word(input logic [2:0] st, input logic [7:0] ch, input logic last);
        result_t r;
        r.status      = st;
        r.char_out    = ch;
        r.last_of_run = last;
        expected_q = {expected_q, r};
    endtask

    // Work out the result words caused by one accepted character.
    task automatic predict_word(input logic [7:0] ch, input logic eol);
        int k;
        int opened;
        int closed;
        int emit;
        opened = -1;
        closed = -1;
        for (k = 0; k < 4; k++)
        begin
            if (ch == opener_for(k[1:0]))
                opened = k;
            if (ch == closer_for(k[1:0]))
                closed = k;
        end

        if (!line_dead)
        begin
            if (opened >= 0)
            begin
                if (open_count >= STACK_DEPTH)
                begin
                    expect_word(ST_OVERFLOW, ch, 1'b1);
                    line_dead = 1'b1;
                end
                else
                begin
                    open_kinds[open_count] = opened[1:0];
                    open_count++;
                end
            end
            else if (closed >= 0)
            begin
                if (open_count == 0)
                begin
                    expect_word(ST_CORRUPT, ch, 1'b1);
                    line_dead = 1'b1;
                end
                else
                begin
                    open_count--;
                    if (open_kinds[open_count] != closed[1:0])
                    begin
                        expect_word(ST_CORRUPT, ch, 1'b1);
                        line_dead = 1'b1;
                    end
                end
            end
            else
            begin
                expect_word(ST_INVALID, ch, 1'b1);
                line_dead = 1'b1;
            end

            // A healthy line end either reports balance or emits the closers, top first.
            if (eol && !line_dead)
            begin
                if (open_count == 0)
                    expect_word(ST_BALANCED, 8'h00, 1'b1);
                else
                begin
                    emit = (open_count < MAX_RESULTS) ? open_count : MAX_RESULTS;
                    for (k = 0; k < emit; k++)
                        expect_word(ST_COMPLETE, closer_for(open_kinds[open_count - 1 - k]),
                                    k == emit - 1);
                end
            end
        end

        if (eol)
        begin
            open_count = 0;
            line_dead  = 1'b0;
        end
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic got_last,
                          input result_t want);
        if (mismatches < 40)
            $display("%0t ns: mismatch in %s: got status %0d char %h last %b pad %h, want status %0d char %h last %b",
                     $time, what, got[2:0], got[10:3], got_last, got[15:11],
                     want.status, want.char_out, want.last_of_run);
        mismatches++;
    endtask

    // Compare one result word with the oldest expectation, field by field.
    task automatic check_word(input logic [15:0] data, input logic last);
        result_t want;
        want = '0;
        if (expected_q.size() == 0)
            report("unexpected word", data, last, want);
        else
        begin
            want = expected_q.pop_front();
            if (data[2:0] != want.status)
                report("status", data, last, want);
            if (data[10:3] != want.char_out)
                report("char_out", data, last, want);
            if (last != want.last_of_run)
                report("last_of_run", data, last, want);
            if (data[15:11] != 5'd0)
                report("padding", data, last, want);
        end
        checked++;
        if (data[2:0] == ST_COMPLETE)
            completions++;
    endtask

    // Results are checked before the prediction of a word accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            open_count  = 0;
            line_dead   = 1'b0;
            mismatches  = 0;
            checked     = 0;
            completions = 0;
            pending     = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_word(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                predict_word(s_tdata, s_tlast);
            pending = expected_q.size();
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench
    import bmc_pkg::*;
();

    localparam int STACK_DEPTH  = 32;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_WORDS = 210;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 28;

    typedef enum int {
        LINE_BALANCED,
        LINE_OPEN,
        LINE_MISMATCH,
        LINE_EMPTY_CLOSE,
        LINE_INVALID,
        LINE_FULL,
        LINE_OVERFLOW,
        LINE_NOISE
    } line_style_e;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int mismatches;
    int pending;
    int checked;
    int completions;

    int cycles       = 0;
    int words_sent   = 0;
    int lines_sent   = 0;
    int random_words = 0;
    int live_words;
    bit calm    = 1'b0;
    bit hold_go = 1'b0;

    // Line under construction and the openers it leaves open.
    logic [7:0] line_q[$];
    int         gen_kinds[$];

    bracket_match_completion #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    bmc_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .completions (completions)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off when asked for.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [7:0] opener_char(input int kind);
        case (kind[1:0])
            KIND_PAREN:  return CH_OPEN_PAREN;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            KIND_CURLY:  return CH_OPEN_CURLY;
            default:     return CH_OPEN_ANGLE;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(input int kind);
        case (kind[1:0])
            KIND_PAREN:  return CH_CLOSE_PAREN;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            KIND_CURLY:  return CH_CLOSE_CURLY;
            default:     return CH_CLOSE_ANGLE;
        endcase
    endfunction

    // Offer one word at a falling edge and hold it until it is taken.
    task automatic send_word(input logic [7:0] ch, input logic eol);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eol;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Stop offering, then wait at falling edges until every expected word has come back.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Random walk of well-nested brackets, never deeper than max_depth.
    task automatic walk(input int steps, input int max_depth);
        int i;
        int k;
        for (i = 0; i < steps; i++)
        begin
            if (gen_kinds.size() == 0 ||
                (gen_kinds.size() < max_depth && $urandom_range(1) == 1))
            begin
                k = $urandom_range(3);
                gen_kinds = {gen_kinds, k};
                line_q = {line_q, opener_char(k)};
            end
            else
            begin
                k = gen_kinds.pop_back();
                line_q = {line_q, closer_char(k)};
            end
        end
    endtask

    // A run of openers of random kinds.
    task automatic fill_openers(input int count);
        int i;
        int k;
        for (i = 0; i < count; i++)
        begin
            k = $urandom_range(3);
            gen_kinds = {gen_kinds, k};
            line_q = {line_q, opener_char(k)};
        end
    endtask

    task automatic close_all;
        int k;
        while (gen_kinds.size() > 0)
        begin
            k = gen_kinds.pop_back();
            line_q = {line_q, closer_char(k)};
        end
    endtask

    // Characters after an error only exercise the ignore path.
    task automatic add_tail;
        int n;
        n = $urandom_range(4);
        repeat (n) line_q = {line_q, 8'($urandom_range(255))};
    endtask

    function automatic bit is_bracket(input logic [7:0] ch);
        int k;
        for (k = 0; k < 4; k++)
            if (ch == opener_char(k) || ch == closer_char(k))
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic build_line(input line_style_e style);
        logic [7:0] ch;
        int k;
        line_q.delete();
        gen_kinds.delete();
        case (style)
            LINE_BALANCED:
            begin
                walk($urandom_range(1, 10), $urandom_range(1, 8));
                close_all();
                live_words = line_q.size();
            end
            LINE_OPEN:
            begin
                walk($urandom_range(1, 10), $urandom_range(1, 8));
                if (gen_kinds.size() == 0)
                begin
                    k = $urandom_range(3);
                    gen_kinds = {gen_kinds, k};
                    line_q = {line_q, opener_char(k)};
                end
                live_words = line_q.size();
            end
            LINE_MISMATCH:
            begin
                walk($urandom_range(1, 8), $urandom_range(1, 6));
                if (gen_kinds.size() == 0)
                begin
                    k = $urandom_range(3);
                    line_q = {line_q, opener_char(k)};
                end
                else
                    k = gen_kinds[gen_kinds.size() - 1];
                line_q = {line_q, closer_char((k + 1 + $urandom_range(2)) % 4)};
                live_words = line_q.size();
                add_tail();
            end
            LINE_EMPTY_CLOSE:
            begin
                if ($urandom_range(1) == 1)
                begin
                    walk($urandom_range(1, 6), $urandom_range(1, 4));
                    close_all();
                end
                line_q = {line_q, closer_char($urandom_range(3))};
                live_words = line_q.size();
                add_tail();
            end
            LINE_INVALID:
            begin
                if ($urandom_range(1) == 1)
                    walk($urandom_range(1, 6), $urandom_range(1, 4));
                ch = 8'($urandom_range(255));
                while (is_bracket(ch))
                    ch = 8'($urandom_range(255));
                line_q = {line_q, ch};
                live_words = line_q.size();
                add_tail();
            end
            LINE_FULL:
            begin
                fill_openers(STACK_DEPTH);
                live_words = line_q.size();
            end
            LINE_OVERFLOW:
            begin
                fill_openers(STACK_DEPTH + 1);
                live_words = line_q.size();
                add_tail();
            end
            default:
            begin
                line_q = {line_q, 8'($urandom_range(255))};
                add_tail();
                live_words = 1;
            end
        endcase
    endtask

    task automatic send_line;
        int i;
        for (i = 0; i < line_q.size(); i++)
            send_word(line_q[i], i == line_q.size() - 1);
        lines_sent++;
    endtask

    function automatic line_style_e pick_style(input int line_idx);
        int r;
        r = $urandom_range(99);
        if (line_idx == 3)
            return LINE_FULL;
        if (line_idx == 10)
            return LINE_OVERFLOW;
        if (r < 24)
            return LINE_BALANCED;
        if (r < 50)
            return LINE_OPEN;
        if (r < 62)
            return LINE_MISMATCH;
        if (r < 70)
            return LINE_EMPTY_CLOSE;
        if (r < 80)
            return LINE_INVALID;
        if (r < 82)
            return LINE_FULL;
        if (r < 84)
            return LINE_OVERFLOW;
        return LINE_NOISE;
    endfunction

    // Stimulus and verdict.
    initial
    begin
        int line_idx;
        line_idx = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Balanced pair, then single and four-kind completions.
        send_word(CH_OPEN_PAREN, 1'b0);
        send_word(CH_CLOSE_PAREN, 1'b1);
        send_word(CH_OPEN_ANGLE, 1'b1);
        send_word(CH_OPEN_PAREN, 1'b0);
        send_word(CH_OPEN_SQUARE, 1'b0);
        send_word(CH_OPEN_CURLY, 1'b0);
        send_word(CH_OPEN_ANGLE, 1'b1);
        // Closer on an empty stack as the only character of a line.
        send_word(CH_CLOSE_SQUARE, 1'b1);
        // Mismatch in mid line; the rest of the line, its end included, is ignored.
        send_word(CH_OPEN_SQUARE, 1'b0);
        send_word(CH_CLOSE_PAREN, 1'b0);
        send_word(8'h78, 1'b0);
        send_word(CH_CLOSE_SQUARE, 1'b1);
        // Invalid character after a closed pair, then an ignored opener.
        send_word(CH_OPEN_CURLY, 1'b0);
        send_word(CH_CLOSE_CURLY, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(CH_OPEN_PAREN, 1'b1);
        // Extremes of the character field, each failing on the last character.
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        // Mismatch on the last character, then a completion after an inner pair.
        send_word(CH_OPEN_PAREN, 1'b0);
        send_word(CH_CLOSE_ANGLE, 1'b1);
        send_word(CH_OPEN_ANGLE, 1'b0);
        send_word(CH_CLOSE_ANGLE, 1'b0);
        send_word(CH_OPEN_CURLY, 1'b1);
        drain();

        // Random lines, mostly well formed up to an optional error.
        while (random_words < RANDOM_WORDS)
        begin
            if (line_idx == 6)
                hold_go = 1'b1;
            calm = (line_idx >= 14 && line_idx < 22);
            if (line_idx == 20)
                drain();
            build_line(pick_style(line_idx));
            send_line();
            random_words += live_words;
            line_idx++;
        end
        calm = 1'b0;

        drain();
        repeat (20) @(negedge clk);

        $display("covered %0d lines in %0d words, %0d result words checked, %0d of them closers",
                 lines_sent, words_sent, checked, completions);
        $display("run included a full stack, an overflow, a long output stall and a drain pause");
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
